// ===== sv/cloc_pkg.sv =====
package cloc_pkg;

  localparam int CELL_W  = 3;
  localparam int POS_W   = 24;
  localparam int RAD_W   = 20;
  localparam int BOX_W   = 24;
  localparam int REACH_W = 2;
  localparam int CFG_W   = 24;
  localparam int CIDX_W  = 2;

  // shifted candidate coordinate: pos +/- box_length
  localparam int SPOS_W  = POS_W + 2;
  // |candidate - stored| never exceeds 2^25 - 2
  localparam int ADIF_W  = POS_W + 1;
  localparam int LIM_W   = RAD_W + 1;

  typedef enum logic [CIDX_W-1:0] {
    REG_BOX_LENGTH     = 2'd0,
    REG_REACH          = 2'd1,
    REG_EXCLUSION_MODE = 2'd2
  } reg_idx_t;

  typedef enum logic {
    MODE_CHECK  = 1'b0,
    MODE_INSERT = 1'b1
  } mode_t;

  typedef struct packed {
    logic [BOX_W-1:0]   box_length;
    logic [REACH_W-1:0] reach;
    logic               exclusion_mode;
  } cfg_t;

  typedef struct packed {
    mode_t             mode;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [CELL_W-1:0] cell_z;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
    logic [RAD_W-1:0]  radius;
    logic              home_ok;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
    logic [RAD_W-1:0] r;
  } slot_t;

  typedef struct packed {
    logic overlap;
    logic cell_full;
  } res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_FILL,
    ST_SLOT,
    ST_DRAIN,
    ST_DONE
  } st_t;

endpackage

// ===== sv/cloc_ram.sv =====
module cloc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/cloc_front.sv =====
module cloc_front #(
  parameter int GRID_SIDE = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       hold,
  input  cloc_pkg::mode_t            mode,
  input  logic [cloc_pkg::CELL_W-1:0] cell_x,
  input  logic [cloc_pkg::CELL_W-1:0] cell_y,
  input  logic [cloc_pkg::CELL_W-1:0] cell_z,
  input  logic [cloc_pkg::POS_W-1:0]  pos_x,
  input  logic [cloc_pkg::POS_W-1:0]  pos_y,
  input  logic [cloc_pkg::POS_W-1:0]  pos_z,
  input  logic [cloc_pkg::RAD_W-1:0]  sphere_radius,
  output logic                       q_valid,
  output cloc_pkg::item_t            q_item,
  input  logic                       q_pop
);
  import cloc_pkg::*;

  localparam int GW = CELL_W + 8;

  item_t       entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        accept;
  item_t       cls;

  // classify: an insert whose home cell lies off the grid is rejected later
  always_comb begin
    cls.mode    = mode;
    cls.cell_x  = cell_x;
    cls.cell_y  = cell_y;
    cls.cell_z  = cell_z;
    cls.pos_x   = pos_x;
    cls.pos_y   = pos_y;
    cls.pos_z   = pos_z;
    cls.radius  = sphere_radius;
    cls.home_ok = (GW'(cell_x) < GW'(GRID_SIDE)) && (GW'(cell_y) < GW'(GRID_SIDE))
                  && (GW'(cell_z) < GW'(GRID_SIDE));
  end

  assign full    = (count == 2'd2) || hold;
  assign accept  = push && !full;
  assign q_valid = (count != 2'd0);
  assign q_item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(accept) - 2'(q_pop && q_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry[wr_ptr] <= cls;
    end
  end

endmodule

// ===== sv/cloc_back.sv =====
module cloc_back #(
  parameter int GRID_SIDE      = 8,
  parameter int SLOTS_PER_CELL = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  cloc_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  cloc_pkg::item_t q_item,
  output logic            q_pop,
  output logic            clearing,
  output logic            res_valid,
  output cloc_pkg::res_t  res,
  input  logic            res_ready
);
  import cloc_pkg::*;

  localparam int NCELL = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int NSLOT = NCELL * SLOTS_PER_CELL;
  localparam int CW    = $clog2(GRID_SIDE);
  localparam int CAW   = $clog2(NCELL);
  localparam int SAW   = $clog2(NSLOT);
  localparam int SW    = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
  localparam int FW    = $clog2(SLOTS_PER_CELL + 1);
  localparam int IW    = ((CW > 4) ? CW : 4) + 2;
  localparam int SQ_W  = 2 * ADIF_W;
  localparam int SUM_W = SQ_W + 2;
  localparam int L2_W  = 2 * LIM_W;
  localparam logic signed [IW-1:0] G_S = IW'(GRID_SIDE);

  st_t state, state_next;

  item_t                    itm;
  logic [3:0]               dx, dy, dz;
  logic [FW-1:0]            sidx;
  logic [FW-1:0]            nfill;
  logic [CAW-1:0]           cell_q;
  logic [CAW-1:0]           clr_cnt;
  logic signed [SPOS_W-1:0] sp [3];
  logic                     acc;
  logic                     full_q;

  // neighbor cell and shifted candidate, one lane per axis
  logic [CELL_W-1:0]        home [3];
  logic [POS_W-1:0]         ipos [3];
  logic signed [IW-1:0]     nb [3];
  logic signed [IW-1:0]     wr [3];
  logic signed [SPOS_W-1:0] sp_n [3];
  logic [2:0]               ax_ok;
  logic [CAW-1:0]           cell_n;
  logic [2:0]               span;
  logic [3:0]               dmax;
  logic                     is_ins;
  logic                     last_cell;
  logic                     step_cell;
  logic [FW-1:0]            nfill_n;

  logic                     fill_we;
  logic [CAW-1:0]           fill_waddr;
  logic [FW-1:0]            fill_wdata;
  logic [CAW-1:0]           fill_raddr;
  logic [FW-1:0]            fill_rdata;
  logic                     slot_we;
  logic [SAW-1:0]           slot_waddr;
  slot_t                    slot_wdata;
  logic [SAW-1:0]           slot_raddr;
  slot_t                    slot_rdata;
  logic                     issue;

  // distance pipeline
  logic                     v1, v2, v3;
  logic signed [SPOS_W-1:0] p1 [3];
  logic [ADIF_W-1:0]        ad [3];
  logic [LIM_W-1:0]         lim;
  logic [SQ_W-1:0]          sq [3];
  logic [L2_W-1:0]          lim2;
  logic [POS_W-1:0]         sv [3];
  logic signed [SPOS_W:0]   df [3];
  logic [SUM_W-1:0]         d2;
  logic                     hit;

  assign is_ins = (itm.mode == MODE_INSERT);
  assign span   = {1'b0, cfg.reach} + 3'd1;
  assign dmax   = {span, 1'b0};
  assign home   = '{itm.cell_x, itm.cell_y, itm.cell_z};
  assign ipos   = '{itm.pos_x, itm.pos_y, itm.pos_z};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (is_ins) begin
        nb[a] = IW'(home[a]);
      end else begin
        nb[a] = $signed(IW'(home[a])) - $signed(IW'(span))
                + $signed(IW'(a == 0 ? dx : (a == 1 ? dy : dz)));
      end
      sp_n[a] = $signed({2'b00, ipos[a]});
      wr[a]   = nb[a];
      if (nb[a] < 0) begin
        wr[a]   = nb[a] + G_S;
        sp_n[a] = $signed({2'b00, ipos[a]}) + $signed({2'b00, cfg.box_length});
      end else if (nb[a] >= G_S) begin
        wr[a]   = nb[a] - G_S;
        sp_n[a] = $signed({2'b00, ipos[a]}) - $signed({2'b00, cfg.box_length});
      end
      ax_ok[a] = (wr[a] >= 0) && (wr[a] < G_S);
    end
    cell_n = CAW'(wr[0][CW-1:0]) * CAW'(GRID_SIDE * GRID_SIDE)
           + CAW'(wr[1][CW-1:0]) * CAW'(GRID_SIDE) + CAW'(wr[2][CW-1:0]);
  end

  assign last_cell = is_ins || (dx == dmax && dy == dmax && dz == dmax);
  assign nfill_n   = (fill_rdata > FW'(SLOTS_PER_CELL)) ? FW'(SLOTS_PER_CELL) : fill_rdata;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == CAW'(NCELL - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.mode == MODE_INSERT && !q_item.home_ok) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_CELL;
          end
        end
      end
      ST_CELL: begin
        if (acc) begin
          state_next = ST_DRAIN;
        end else if (&ax_ok) begin
          state_next = ST_FILL;
        end else if (last_cell) begin
          state_next = ST_DRAIN;
        end
      end
      ST_FILL: begin
        if (is_ins) begin
          state_next = ST_DONE;
        end else if (nfill_n != '0) begin
          state_next = ST_SLOT;
        end else if (last_cell) begin
          state_next = ST_DRAIN;
        end else begin
          state_next = ST_CELL;
        end
      end
      ST_SLOT: begin
        if (acc) begin
          state_next = ST_DRAIN;
        end else if (sidx == nfill - FW'(1)) begin
          state_next = last_cell ? ST_DRAIN : ST_CELL;
        end
      end
      ST_DRAIN: begin
        if (!v1 && !v2 && !v3) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and memory ports
  always_comb begin
    q_pop      = 1'b0;
    clearing   = 1'b0;
    res_valid  = 1'b0;
    fill_we    = 1'b0;
    fill_waddr = cell_q;
    fill_wdata = fill_rdata + FW'(1);
    fill_raddr = cell_n;
    slot_we    = 1'b0;
    slot_waddr = SAW'(cell_q) * SAW'(SLOTS_PER_CELL) + SAW'(fill_rdata[SW-1:0]);
    slot_wdata = '{x: itm.pos_x, y: itm.pos_y, z: itm.pos_z, r: itm.radius};
    slot_raddr = SAW'(cell_q) * SAW'(SLOTS_PER_CELL) + SAW'(sidx[SW-1:0]);
    issue      = 1'b0;
    step_cell  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        clearing   = 1'b1;
        fill_we    = 1'b1;
        fill_waddr = clr_cnt;
        fill_wdata = '0;
      end
      ST_IDLE: begin
        q_pop = q_valid;
      end
      ST_CELL: begin
        step_cell = !acc && !(&ax_ok) && !last_cell;
      end
      ST_FILL: begin
        if (is_ins) begin
          fill_we = (fill_rdata < FW'(SLOTS_PER_CELL));
          slot_we = fill_we;
        end else begin
          step_cell = (nfill_n == '0) && !last_cell;
        end
      end
      ST_SLOT: begin
        issue     = !acc;
        step_cell = !acc && (sidx == nfill - FW'(1)) && !last_cell;
      end
      ST_DRAIN: begin
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
    res.overlap   = acc;
    res.cell_full = full_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      acc     <= 1'b0;
      full_q  <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      v2    <= v1;
      v3    <= v2;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + CAW'(1);
      end
      if (state == ST_IDLE && q_valid) begin
        acc    <= 1'b0;
        full_q <= (q_item.mode == MODE_INSERT) && !q_item.home_ok;
      end else if (v3 && hit) begin
        acc <= 1'b1;
      end
      if (state == ST_FILL && is_ins) begin
        full_q <= (fill_rdata >= FW'(SLOTS_PER_CELL));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      itm <= q_item;
      dx  <= '0;
      dy  <= '0;
      dz  <= '0;
    end
    if (state == ST_CELL) begin
      cell_q <= cell_n;
      sp     <= sp_n;
    end
    if (state == ST_FILL) begin
      nfill <= nfill_n;
      sidx  <= '0;
    end
    if (state == ST_SLOT) begin
      sidx <= sidx + FW'(1);
    end
    if (step_cell) begin
      if (dz != dmax) begin
        dz <= dz + 4'd1;
      end else begin
        dz <= '0;
        if (dy != dmax) begin
          dy <= dy + 4'd1;
        end else begin
          dy <= '0;
          dx <= dx + 4'd1;
        end
      end
    end
  end

  // distance pipeline: read, abs diff, squares, compare
  assign sv = '{slot_rdata.x, slot_rdata.y, slot_rdata.z};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      df[a] = $signed({p1[a][SPOS_W-1], p1[a]}) - $signed({3'b000, sv[a]});
    end
    d2  = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    hit = (d2 < SUM_W'(lim2));
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p1 <= sp;
    end
    for (int a = 0; a < 3; a++) begin
      ad[a] <= df[a] < 0 ? ADIF_W'(-df[a]) : ADIF_W'(df[a]);
      sq[a] <= SQ_W'(ad[a]) * SQ_W'(ad[a]);
    end
    lim  <= cfg.exclusion_mode ? LIM_W'(slot_rdata.r)
                               : LIM_W'(slot_rdata.r) + LIM_W'(itm.radius);
    lim2 <= L2_W'(lim) * L2_W'(lim);
  end

  cloc_ram #(.WIDTH(FW), .DEPTH(NCELL)) u_fill (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (fill_raddr),
    .rdata (fill_rdata)
  );

  cloc_ram #(.WIDTH($bits(slot_t)), .DEPTH(NSLOT)) u_slot (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  a_done_drained: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!v1 && !v2 && !v3))
    else $error("result raised with slot reads in flight");

  a_slot_in_fill: assert property (@(posedge clk) disable iff (rst)
    issue |-> (sidx < nfill))
    else $error("slot read beyond cell fill");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    slot_we |-> (fill_rdata < FW'(SLOTS_PER_CELL) && is_ins))
    else $error("slot write into full cell");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!q_pop && !res_valid))
    else $error("item taken during clearing pass");

endmodule

// ===== sv/cell_list_overlap_check.sv =====
// channel | handshake                 | beat
// input   | push / full               | mode, cell_x/y/z, pos_x/y/z, sphere_radius
// result  | pop / empty               | overlap, cell_full
// config  | cfg_we (no wait)          | cfg_index, cfg_wdata
//
// Check: scans (2*reach+3)^3 neighbor cells, one stored sphere a cycle through the slot
// RAM read port; ends early on the first overlap. Insert: reads the home cell's fill count
// and writes the sphere into its next free slot, or reports cell_full.
// Reset: a clearing pass zeroes the fill counts of all GRID_SIDE^3 cells; full stays high.
// A two-beat input queue and the result register let each side stall on its own.
module cell_list_overlap_check #(
  parameter int GRID_SIDE      = 8,
  parameter int SLOTS_PER_CELL = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         mode,
  input  logic [cloc_pkg::CELL_W-1:0]  cell_x,
  input  logic [cloc_pkg::CELL_W-1:0]  cell_y,
  input  logic [cloc_pkg::CELL_W-1:0]  cell_z,
  input  logic [cloc_pkg::POS_W-1:0]   pos_x,
  input  logic [cloc_pkg::POS_W-1:0]   pos_y,
  input  logic [cloc_pkg::POS_W-1:0]   pos_z,
  input  logic [cloc_pkg::RAD_W-1:0]   sphere_radius,
  output logic                         empty,
  input  logic                         pop,
  output logic                         overlap,
  output logic                         cell_full,
  input  logic                         cfg_we,
  input  logic [cloc_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [cloc_pkg::CFG_W-1:0]   cfg_wdata
);
  import cloc_pkg::*;

  cfg_t  cfg;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;
  logic  clearing;
  logic  res_valid;
  res_t  res;
  logic  res_ready;
  logic  out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_length     <= '1;
      cfg.reach          <= '0;
      cfg.exclusion_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BOX_LENGTH:     cfg.box_length     <= cfg_wdata[BOX_W-1:0];
        REG_REACH:          cfg.reach          <= cfg_wdata[REACH_W-1:0];
        REG_EXCLUSION_MODE: cfg.exclusion_mode <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  cloc_front #(.GRID_SIDE(GRID_SIDE)) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .hold          (clearing),
    .mode          (mode_t'(mode)),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .cell_z        (cell_z),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .sphere_radius (sphere_radius),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  cloc_back #(.GRID_SIDE(GRID_SIDE), .SLOTS_PER_CELL(SLOTS_PER_CELL)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // result register: refilled in the cycle its beat is popped
  assign res_ready = !out_valid || pop;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      overlap   <= res.overlap;
      cell_full <= res.cell_full;
    end
  end

endmodule
